FILE: rtl/iva_pkg.sv
// ----------------------------------------------------------------------------
// iva_pkg
// Shared types and constants of the interrupt vector allocator: the request
// and response payloads, the operation codes, the controller states and the
// command group from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iva_pkg;

    localparam int KIND_W = 3;
    localparam int VEC_W = 8;
    localparam int TAG_PORT_W = 32;
    localparam int CHUNK_W = 8;

    // All vectors of a bitmap chunk in use
    localparam logic [CHUNK_W-1:0] CHUNK_FULL = 8'hff;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_OS  = 3'd0,
        KIND_ALLOC_EXT = 3'd1,
        KIND_FREE      = 3'd2,
        KIND_BIND      = 3'd3,
        KIND_GET       = 3'd4
    } iva_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [VEC_W-1:0]      vector;
        logic [TAG_PORT_W-1:0] handler;
    } iva_req_t;

    typedef struct packed {
        logic [VEC_W-1:0]      result_vector;
        logic                  found;
        logic [TAG_PORT_W-1:0] handler_value;
    } iva_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EXEC = 2'd2,
        ST_DONE = 2'd3
    } iva_state_t;

    typedef struct packed {
        logic take_req;
        logic scan;
        logic exec;
        logic load_rsp;
    } iva_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/iva_ctrl.sv
// ----------------------------------------------------------------------------
// iva_ctrl
// Controller of the allocator: walks each transaction through scan, execute
// and response load, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output iva_pkg::iva_cmd_t   cmd
);
    import iva_pkg::*;

    iva_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // output slot is free or drains this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/iva_dp.sv
// ----------------------------------------------------------------------------
// iva_dp
// Datapath of the allocator: allocation bitmap, per-vector default flags,
// handler memory, default handler register, chunk search and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_dp #(
    parameter int VECTOR_COUNT   = 256,
    parameter int FIRST_MANAGED  = 32,
    parameter int FIRST_EXTERNAL = 48,
    parameter int HANDLER_BITS   = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire iva_pkg::iva_cmd_t          cmd,
    input  wire iva_pkg::iva_req_t          req_data,
    input  wire logic                       cfg_we,
    input  wire logic [iva_pkg::TAG_PORT_W-1:0] cfg_data,
    output iva_pkg::iva_rsp_t               rsp_data
);
    import iva_pkg::*;

    localparam int MAP_BYTES = (VECTOR_COUNT - FIRST_MANAGED) / 8;
    localparam int MAP_SLOTS = (MAP_BYTES > 0) ? MAP_BYTES : 1;
    localparam int CHW       = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam int FE_LO     = (FIRST_EXTERNAL < FIRST_MANAGED) ? FIRST_MANAGED
                                                                : FIRST_EXTERNAL;
    localparam int FE_CLAMP  = (FE_LO > VECTOR_COUNT) ? VECTOR_COUNT : FE_LO;
    localparam int EXT_CHUNK = (FE_CLAMP - FIRST_MANAGED) / 8;
    localparam int VIW       = $clog2(VECTOR_COUNT);
    localparam int TAG_W     = (HANDLER_BITS < TAG_PORT_W) ? HANDLER_BITS : TAG_PORT_W;

    localparam logic [VEC_W:0] VC9 = (VEC_W+1)'(VECTOR_COUNT);
    localparam logic [VEC_W:0] FM9 = (VEC_W+1)'(FIRST_MANAGED);
    localparam logic [5:0]     MB6 = 6'(MAP_BYTES);

    // state
    logic [CHUNK_W-1:0]      map_reg [MAP_SLOTS];
    logic [VECTOR_COUNT-1:0] use_dflt_reg;
    logic [TAG_W-1:0]        handler_mem [VECTOR_COUNT];
    logic [TAG_PORT_W-1:0]   default_reg;

    // per-transaction registers
    iva_req_t         req_reg;
    logic             hit_reg;
    logic [CHW-1:0]   chunk_reg;
    logic [TAG_W-1:0] rd_reg;
    iva_rsp_t         res_reg, res_next;
    iva_rsp_t         rsp_reg;

    // request decode
    logic [VEC_W:0]   vec9;
    logic [VEC_W:0]   off9;
    logic             in_range;
    logic             managed;
    logic [CHW-1:0]   req_chunk;
    logic [2:0]       req_bit;
    logic [VIW-1:0]   vidx;
    logic [TAG_W-1:0] tag;

    assign vec9      = {1'b0, req_reg.vector};
    assign off9      = vec9 - FM9;
    assign in_range  = (vec9 < VC9);
    assign managed   = in_range && (vec9 >= FM9) && (off9[VEC_W:3] < MB6);
    assign req_chunk = off9[3 +: CHW];
    assign req_bit   = off9[2:0];
    assign vidx      = req_reg.vector[VIW-1:0];
    assign tag       = req_reg.handler[TAG_W-1:0];

    // chunk search: lowest chunk of the region that still has a free vector
    logic [MAP_SLOTS-1:0] avail;
    logic [MAP_SLOTS-1:0] first_avail;
    logic [CHW-1:0]       scan_idx;

    always_comb
    begin
        for (int i = 0; i < MAP_SLOTS; i++)
        begin
            avail[i] = (map_reg[i] != CHUNK_FULL) && (i < MAP_BYTES) &&
                       ((req_reg.kind == KIND_ALLOC_OS) ? (i < EXT_CHUNK)
                                                        : (i >= EXT_CHUNK));
        end
        first_avail = avail & (~avail + 1'b1);
        scan_idx    = '0;
        for (int i = 0; i < MAP_SLOTS; i++)
        begin
            if (first_avail[i])
            begin
                scan_idx = scan_idx | CHW'(i);
            end
        end
    end

    // lowest free bit of the chosen chunk
    logic [CHUNK_W-1:0] cur_chunk;
    logic [CHUNK_W-1:0] free_bits;
    logic [CHUNK_W-1:0] low_free;
    logic [2:0]         bit_idx;
    logic [VEC_W:0]     alloc_vec9;

    always_comb
    begin
        cur_chunk = map_reg[chunk_reg];
        free_bits = ~cur_chunk;
        low_free  = free_bits & (~free_bits + 1'b1);
        bit_idx   = '0;
        for (int j = 0; j < CHUNK_W; j++)
        begin
            if (low_free[j])
            begin
                bit_idx = bit_idx | 3'(j);
            end
        end
        alloc_vec9 = FM9 + (VEC_W+1)'({chunk_reg, 3'b000}) + (VEC_W+1)'(bit_idx);
    end

    // execute-step updates
    logic               map_we;
    logic [CHW-1:0]     map_widx;
    logic [CHUNK_W-1:0] map_wdata;
    logic               dflt_we;
    logic [VIW-1:0]     dflt_widx;
    logic               dflt_wval;
    logic               mem_we;
    logic [VIW-1:0]     mem_widx;

    always_comb
    begin
        map_we    = 1'b0;
        map_widx  = req_chunk;
        map_wdata = map_reg[req_chunk];
        dflt_we   = 1'b0;
        dflt_widx = vidx;
        dflt_wval = 1'b1;
        mem_we    = 1'b0;
        mem_widx  = vidx;
        res_next  = '0;
        unique case (req_reg.kind)
            KIND_ALLOC_OS, KIND_ALLOC_EXT:
            begin
                if (hit_reg)
                begin
                    map_we                 = 1'b1;
                    map_widx               = chunk_reg;
                    map_wdata              = cur_chunk | low_free;
                    dflt_we                = 1'b1;
                    dflt_widx              = alloc_vec9[VIW-1:0];
                    dflt_wval              = (tag == '0);
                    mem_we                 = (tag != '0);
                    mem_widx               = alloc_vec9[VIW-1:0];
                    res_next.result_vector = alloc_vec9[VEC_W-1:0];
                    res_next.found         = 1'b1;
                end
            end
            KIND_FREE:
            begin
                map_we    = managed;
                map_wdata = map_reg[req_chunk] & ~(CHUNK_W'(1) << req_bit);
                dflt_we   = in_range;
                dflt_wval = 1'b1;
            end
            KIND_BIND:
            begin
                map_we    = managed;
                map_wdata = map_reg[req_chunk] | (CHUNK_W'(1) << req_bit);
                dflt_we   = in_range;
                dflt_wval = 1'b0;
                mem_we    = in_range;
            end
            KIND_GET:
            begin
                if (in_range)
                begin
                    res_next.handler_value = use_dflt_reg[vidx] ? default_reg
                                                                : TAG_PORT_W'(rd_reg);
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_SLOTS; i++)
            begin
                map_reg[i] <= '0;
            end
            use_dflt_reg <= '1;
            default_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                default_reg <= cfg_data;
            end
            if (cmd.exec && map_we)
            begin
                map_reg[map_widx] <= map_wdata;
            end
            if (cmd.exec && dflt_we)
            begin
                use_dflt_reg[dflt_widx] <= dflt_wval;
            end
        end
    end

    // handler memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            handler_mem[mem_widx] <= tag;
        end
        if (cmd.scan && in_range)
        begin
            rd_reg <= handler_mem[vidx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.scan)
        begin
            hit_reg   <= |avail;
            chunk_reg <= scan_idx;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/interrupt_vector_allocator_core.sv
// ----------------------------------------------------------------------------
// interrupt_vector_allocator_core
// Interrupt vector allocator with a first-fit bitmap over managed vectors.
//
// Request channel (req_valid / req_stall / req_data): one transaction per
// operation: allocate in the OS or external region, free, bind or get.
// Every request produces exactly one response on rsp_valid / rsp_stall /
// rsp_data, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the default
// handler tag; cfg_ready is always high. Write it only while idle.
// Timing: a request is taken in the idle state. The steps are then the
// chunk search together with the handler memory read, then the bitmap and
// memory update, then the response load. req_stall is high from acceptance
// until the response is loaded.
// The response register lets the next request be accepted while a response
// is still stalled; that request then waits in its last step until the
// response register drains.
// Reset clears the bitmap, marks every vector as using the default handler
// and clears the default handler to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_vector_allocator_core #(
    parameter int VECTOR_COUNT   = 256,
    parameter int FIRST_MANAGED  = 32,
    parameter int FIRST_EXTERNAL = 48,
    parameter int HANDLER_BITS   = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire iva_pkg::iva_req_t              req_data,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output iva_pkg::iva_rsp_t                   rsp_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [iva_pkg::TAG_PORT_W-1:0] cfg_data
);
    import iva_pkg::*;

    iva_cmd_t cmd;

    assign cfg_ready = 1'b1;

    iva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    iva_dp #(
        .VECTOR_COUNT   (VECTOR_COUNT),
        .FIRST_MANAGED  (FIRST_MANAGED),
        .FIRST_EXTERNAL (FIRST_EXTERNAL),
        .HANDLER_BITS   (HANDLER_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

    // one transaction in flight: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while a transaction was in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.found) |-> (rsp_data.result_vector == 8'd0))
        else $error("nonzero vector without a successful allocation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.found) |->
            ((rsp_data.handler_value == 32'd0) &&
             ({1'b0, rsp_data.result_vector} >= 9'(FIRST_MANAGED))))
        else $error("allocation result outside the managed range");

    // response load always returns the controller to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_stall)
        else $error("response loaded without returning to idle");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interrupt vector allocator core. Requests are
// queued by phase: a directed set, then mixed random traffic with allocation
// and free bursts, plus a flood that fills the external region. Each accepted
// request runs through a local model of the bitmap and handler table. Every
// response is compared field by field with the oldest expected response. The
// default handler is rewritten between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    import iva_pkg::*;

    localparam int VECTOR_COUNT   = 256;
    localparam int FIRST_MANAGED  = 32;
    localparam int FIRST_EXTERNAL = 48;
    localparam int KIND_MAX       = (1 << KIND_W) - 1;
    localparam int IDLE_PCT       = 31;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    iva_req_t              req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    iva_rsp_t              rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TAG_PORT_W-1:0] cfg_data = '0;

    iva_req_t pending_reqs[$];
    iva_rsp_t expected_rsps[$];

    // Local copy of the allocator state
    bit                    vec_used [VECTOR_COUNT];
    bit                    on_default [VECTOR_COUNT];
    logic [TAG_PORT_W-1:0] tag_table [VECTOR_COUNT];
    logic [TAG_PORT_W-1:0] default_tag;

    bit steady_flow = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    interrupt_vector_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic iva_rsp_t predict_response(input iva_req_t req);
        iva_rsp_t rsp;
        int       lo;
        int       hi;
        int       v;
        rsp = '0;
        v = int'(req.vector);
        case (req.kind)
            KIND_ALLOC_OS, KIND_ALLOC_EXT:
            begin
                lo = (req.kind == KIND_ALLOC_OS) ? FIRST_MANAGED : FIRST_EXTERNAL;
                hi = (req.kind == KIND_ALLOC_OS) ? FIRST_EXTERNAL : VECTOR_COUNT;
                // first fit; a full chunk simply has no free bit to find
                for (int i = lo; i < hi; i++)
                begin
                    if (!vec_used[i])
                    begin
                        vec_used[i] = 1'b1;
                        on_default[i] = (req.handler == '0);
                        if (req.handler != '0)
                            tag_table[i] = req.handler;
                        rsp.result_vector = i[VEC_W-1:0];
                        rsp.found = 1'b1;
                        return rsp;
                    end
                end
            end
            KIND_FREE:
            begin
                if (v >= FIRST_MANAGED)
                    vec_used[v] = 1'b0;
                on_default[v] = 1'b1;
            end
            KIND_BIND:
            begin
                if (v >= FIRST_MANAGED)
                    vec_used[v] = 1'b1;
                on_default[v] = 1'b0;
                tag_table[v] = req.handler;
            end
            KIND_GET:
                rsp.handler_value = on_default[v] ? default_tag : tag_table[v];
            default:
                ;
        endcase
        return rsp;
    endfunction

    function automatic iva_req_t make_req(input logic [KIND_W-1:0] kind,
                                          input logic [VEC_W-1:0] vec,
                                          input logic [TAG_PORT_W-1:0] tag);
        iva_req_t req;
        req.kind = kind;
        req.vector = vec;
        req.handler = tag;
        return req;
    endfunction

    function automatic logic [TAG_PORT_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '0;
        if (roll < 30)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [VEC_W-1:0] pick_vector();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return VEC_W'($urandom_range(FIRST_MANAGED, FIRST_EXTERNAL - 1));
        if (roll < 80)
            return VEC_W'($urandom_range(FIRST_EXTERNAL, VECTOR_COUNT - 1));
        return VEC_W'($urandom_range(0, VECTOR_COUNT - 1));
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Request driver: a stalled transaction holds its payload
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_rsps.push_back(predict_response(req_data));
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req_data <= pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        iva_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                    note_mismatch("unexpected response", 64'(rsp_data), '0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.result_vector !== want.result_vector)
                        note_mismatch("result_vector", 64'(rsp_data.result_vector),
                                      64'(want.result_vector));
                    if (rsp_data.found !== want.found)
                        note_mismatch("found", 64'(rsp_data.found), 64'(want.found));
                    if (rsp_data.handler_value !== want.handler_value)
                        note_mismatch("handler_value", 64'(rsp_data.handler_value),
                                      64'(want.handler_value));
                end
            end
            rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_tag(input logic [TAG_PORT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        default_tag = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic iva_req_t random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return make_req(KIND_ALLOC_OS, VEC_W'($urandom), pick_tag());
        if (roll < 25)
            return make_req(KIND_ALLOC_EXT, VEC_W'($urandom), pick_tag());
        if (roll < 45)
            return make_req(KIND_FREE, pick_vector(), $urandom);
        if (roll < 60)
            return make_req(KIND_BIND, pick_vector(), pick_tag());
        if (roll < 95)
            return make_req(KIND_GET, pick_vector(), $urandom);
        return make_req(KIND_W'($urandom_range(KIND_GET + 1, KIND_MAX)),
                        VEC_W'($urandom), $urandom);
    endfunction

    task automatic queue_traffic(input int count);
        int       n;
        int       roll;
        int       len;
        iva_req_t req;
        iva_kind_t kind;
        n = 0;
        while (n < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                // allocation burst, long enough to run the OS region dry
                len = $urandom_range(4, 18);
                kind = ($urandom_range(0, 1) != 0) ? KIND_ALLOC_EXT : KIND_ALLOC_OS;
                repeat (len) pending_reqs.push_back(make_req(kind, VEC_W'($urandom),
                                                             pick_tag()));
                n += len;
            end
            else if (roll < 25)
            begin
                len = $urandom_range(2, 8);
                repeat (len) pending_reqs.push_back(make_req(KIND_FREE, pick_vector(),
                                                             $urandom));
                n += len;
            end
            else
            begin
                req = random_request();
                pending_reqs.push_back(req);
                if (req.kind <= KIND_GET)
                    n++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < VECTOR_COUNT; i++)
        begin
            vec_used[i] = 1'b0;
            on_default[i] = 1'b1;
            tag_table[i] = '0;
        end
        default_tag = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_default_tag('1);
        pending_reqs.push_back(make_req(KIND_GET, 8'd0, '0));
        pending_reqs.push_back(make_req(KIND_GET, 8'd255, '1));
        pending_reqs.push_back(make_req(KIND_ALLOC_OS, 8'd0, '0));
        pending_reqs.push_back(make_req(KIND_GET, 8'd32, '0));
        pending_reqs.push_back(make_req(KIND_ALLOC_OS, 8'd255, '1));
        pending_reqs.push_back(make_req(KIND_GET, 8'd33, '0));
        pending_reqs.push_back(make_req(KIND_ALLOC_EXT, 8'd0, 32'h0000_0001));
        pending_reqs.push_back(make_req(KIND_ALLOC_EXT, 8'd0, '0));
        pending_reqs.push_back(make_req(KIND_FREE, 8'd48, '0));
        pending_reqs.push_back(make_req(KIND_ALLOC_EXT, 8'd0, 32'h8000_0000));
        // unmanaged vector, zero tag stored as a real tag
        pending_reqs.push_back(make_req(KIND_BIND, 8'd5, '0));
        pending_reqs.push_back(make_req(KIND_GET, 8'd5, '0));
        pending_reqs.push_back(make_req(KIND_FREE, 8'd5, '0));
        pending_reqs.push_back(make_req(KIND_GET, 8'd5, '0));
        pending_reqs.push_back(make_req(KIND_BIND, 8'd255, 32'h1234_5678));
        pending_reqs.push_back(make_req(KIND_GET, 8'd255, '0));
        pending_reqs.push_back(make_req(KIND_FREE, 8'd0, '1));
        pending_reqs.push_back(make_req(KIND_BIND, 8'd47, 32'h0f0f_f0f0));
        pending_reqs.push_back(make_req(KIND_W'(KIND_GET + 1), 8'd0, '0));
        pending_reqs.push_back(make_req(KIND_W'(KIND_GET + 2), 8'd255, '1));
        pending_reqs.push_back(make_req(KIND_W'(KIND_MAX), 8'd170, 32'h5555_aaaa));
        pending_reqs.push_back(make_req(KIND_FREE, 8'd33, '0));
        pending_reqs.push_back(make_req(KIND_GET, 8'd33, '0));
        pending_reqs.push_back(make_req(KIND_ALLOC_OS, 8'd0, 32'h0000_0007));
        wait_idle();

        write_default_tag('0);
        queue_traffic(150);
        wait_idle();

        write_default_tag($urandom);
        steady_flow = 1'b1;
        queue_traffic(150);
        wait_idle();
        steady_flow = 1'b0;

        // flood the external region until it reports full
        write_default_tag(32'h8000_0001);
        repeat (212) pending_reqs.push_back(make_req(KIND_ALLOC_EXT, VEC_W'($urandom),
                                                     pick_tag()));
        queue_traffic(60);
        wait_idle();

        write_default_tag($urandom);
        queue_traffic(120);
        wait_idle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/iva_pkg.sv
rtl/iva_ctrl.sv
rtl/iva_dp.sv
rtl/interrupt_vector_allocator_core.sv
tb/tb.sv
